### src/crt_pkg.sv
// Shared types, codes and constants for the client recency tracker.
package crt_pkg;

  // Default sizing handed to the top level
  localparam int TableEntriesDef = 512;
  localparam int TimeBitsDef     = 32;

  // Field widths fixed by the interface
  localparam int AddrW   = 32;
  localparam int NowW    = 32;
  localparam int OnlineW = 10;
  localparam int TotalW  = 32;
  localparam int ActW    = 16;
  localparam int UpW     = 32;
  localparam int WinW    = 16;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 2;

  // Online counts saturate at the field maximum
  localparam int OnlineMax = 1023;

  // Reset values of the configuration registers
  localparam logic [WinW-1:0] WindowRst = 16'd300;
  localparam logic [CfgW-1:0] StartRst  = 32'd0;

  // Action codes on the input port
  localparam logic [1:0] ActStart = 2'd0;
  localparam logic [1:0] ActEnd   = 2'd1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWindow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStart  = 2'd1;

  typedef enum logic [1:0] {
    K_START,
    K_END,
    K_QUERY
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_e;

  // One classified beat travelling from front to back
  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] addr;
    logic [NowW-1:0]  now;
  } item_t;

endpackage

### src/client_recency_tracker_top.sv
// Top level of the client recency tracker: configuration registers, front and back.
// The back end takes one beat at a time: it scans every filled slot, at most TABLE_ENTRIES,
// sequentially through the single read port of the client table, and takes no new beat
// until the result of the last one has been loaded.
// A two-beat queue lets input be taken while the back end scans or a result waits.
// Reset clears counters and fill count at once; no clearing pass over the table.
module client_recency_tracker_top #(
  parameter int TABLE_ENTRIES = crt_pkg::TableEntriesDef,
  parameter int TIME_BITS     = crt_pkg::TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] client_addr_i,
  input  logic [31:0] now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  live_count_o,
  output logic [9:0]  live_peak_o,
  output logic [31:0] request_count_o,
  output logic [15:0] open_conns_o,
  output logic [15:0] peak_active_o,
  output logic [31:0] uptime_o
);
  import crt_pkg::*;

  logic [WinW-1:0] window_q;
  logic [CfgW-1:0] start_q;
  logic            q_valid, q_pop;
  item_t           q_item;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowRst;
      start_q  <= StartRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgWindow) window_q <= cfg_data_i[WinW-1:0];
      if (cfg_idx_i == CfgStart)  start_q  <= cfg_data_i;
    end
  end

  crt_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .client_addr_i,
    .now_i,
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  crt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TIME_BITS     (TIME_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_item_i     (q_item),
    .window_i     (window_q),
    .start_time_i (start_q),
    .out_valid_o,
    .out_ready_i,
    .live_count_o,
    .live_peak_o,
    .request_count_o,
    .open_conns_o,
    .peak_active_o,
    .uptime_o
  );

endmodule

### src/crt_front.sv
// Front end: accepts input beats, classifies the action and queues them.
module crt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [31:0]         client_addr_i,
  input  logic [31:0]         now_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output crt_pkg::item_t      q_item_o
);
  import crt_pkg::*;

  item_t       slot_q [2];
  logic        wp_q, wp_d;
  logic        rp_q, rp_d;
  logic [1:0]  fill_q, fill_d;
  logic        push, pop;
  item_t       cls;

  // Classify the action; unused code behaves as a query
  always_comb begin
    cls.addr = client_addr_i;
    cls.now  = now_i;
    unique case (action_i)
      ActStart: cls.kind = K_START;
      ActEnd:   cls.kind = K_END;
      default:  cls.kind = K_QUERY;
    endcase
  end

  assign in_ready_o = (fill_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (fill_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = slot_q[rp_q];

  // Advance pointers and fill level
  always_comb begin
    wp_d   = push ? ~wp_q : wp_q;
    rp_d   = pop ? ~rp_q : rp_q;
    fill_d = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= cls;
    end
  end

endmodule

### src/crt_back.sv
// Back end: scans the client table, updates it and the counters, holds the result.
module crt_back #(
  parameter int TABLE_ENTRIES = crt_pkg::TableEntriesDef,
  parameter int TIME_BITS     = crt_pkg::TimeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  crt_pkg::item_t      q_item_i,
  input  logic [15:0]         window_i,
  input  logic [31:0]         start_time_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [9:0]          live_count_o,
  output logic [9:0]          live_peak_o,
  output logic [31:0]         request_count_o,
  output logic [15:0]         open_conns_o,
  output logic [15:0]         peak_active_o,
  output logic [31:0]         uptime_o
);
  import crt_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int CW = UW + 1;
  localparam int TB = TIME_BITS;

  // Client table
  logic [AddrW-1:0] addr_mem [TABLE_ENTRIES];
  logic [TB-1:0]    seen_mem [TABLE_ENTRIES];
  logic [AddrW-1:0] rd_addr_q;
  logic [TB-1:0]    rd_seen_q;

  state_e           state_q, state_d;
  item_t            cur_q;
  logic [UW-1:0]    used_q;
  logic [UW-1:0]    iss_q;
  logic             rv_q;
  logic [IW-1:0]    ridx_q;
  logic [CW-1:0]    cnt_q;
  logic             hit_q, hit_on_q;
  logic [IW-1:0]    hit_idx_q;
  logic [IW-1:0]    old_idx_q;
  logic [TB-1:0]    old_t_q;
  logic             old_on_q;

  logic [TotalW-1:0] total_q, total_d;
  logic [ActW-1:0]   act_q, act_d;
  logic [ActW-1:0]   apeak_q, apeak_d;
  logic [OnlineW-1:0] opeak_q, opeak_d;

  logic               out_valid_q;
  logic [OnlineW-1:0] o_online_q, o_opeak_q;
  logic [TotalW-1:0]  o_total_q;
  logic [ActW-1:0]    o_act_q, o_apeak_q;
  logic [UpW-1:0]     o_up_q;

  logic               out_free, is_start, full, more, rd_on, mem_we, load_out;
  logic [TB-1:0]      now_t, base_t;
  logic [IW-1:0]      widx;
  logic [CW-1:0]      cnt_new;
  logic [OnlineW-1:0] online_sat;
  logic [UpW-1:0]     up_val;

  assign now_t    = TB'(cur_q.now);
  assign base_t   = TB'(start_time_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign is_start = (cur_q.kind == K_START);
  assign full     = (used_q == UW'(TABLE_ENTRIES));
  assign more     = (iss_q < used_q);
  assign rd_on    = (rd_seen_q >= now_t) || ((now_t - rd_seen_q) <= TB'(window_i));

  // Slot to write: refreshed entry, next free slot, or the oldest entry
  always_comb begin
    priority if (hit_q) widx = hit_idx_q;
    else if (full)      widx = old_idx_q;
    else                widx = used_q[IW-1:0];
  end

  // Online count after the update, from the pre-update scan
  always_comb begin
    priority if (!is_start) cnt_new = cnt_q;
    else if (hit_q)         cnt_new = cnt_q - CW'(hit_on_q) + CW'(1);
    else if (!full)         cnt_new = cnt_q + CW'(1);
    else                    cnt_new = cnt_q - CW'(old_on_q) + CW'(1);
  end

  always_comb begin
    if (int'(cnt_new) > OnlineMax) online_sat = OnlineW'(OnlineMax);
    else                           online_sat = OnlineW'(cnt_new);
  end

  // Counter updates
  always_comb begin
    total_d = total_q;
    act_d   = act_q;
    unique case (cur_q.kind)
      K_START: begin
        if (total_q != '1) total_d = total_q + TotalW'(1);
        if (act_q != '1)   act_d   = act_q + ActW'(1);
      end
      K_END: begin
        if (act_q != '0) act_d = act_q - ActW'(1);
      end
      default: ;
    endcase
    apeak_d = (is_start && act_d > apeak_q) ? act_d : apeak_q;
    opeak_d = (is_start && online_sat > opeak_q) ? online_sat : opeak_q;
    up_val  = (now_t > base_t) ? UpW'(now_t - base_t) : '0;
  end

  // Sequencer: take a beat, scan the used slots, then finish
  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    mem_we   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!more && !rv_q) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          mem_we   = is_start;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      addr_mem[widx] <= cur_q.addr;
      seen_mem[widx] <= now_t;
    end
    rd_addr_q <= addr_mem[iss_q[IW-1:0]];
    rd_seen_q <= seen_mem[iss_q[IW-1:0]];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      iss_q       <= '0;
      rv_q        <= 1'b0;
      total_q     <= '0;
      act_q       <= '0;
      apeak_q     <= '0;
      opeak_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        iss_q <= '0;
        rv_q  <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        rv_q <= more;
        if (more) iss_q <= iss_q + UW'(1);
      end
      if (load_out) begin
        total_q <= total_d;
        act_q   <= act_d;
        apeak_q <= apeak_d;
        opeak_q <= opeak_d;
        if (is_start && !hit_q && !full) used_q <= used_q + UW'(1);
      end
      if (load_out)         out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Scan datapath: match, oldest entry and online count
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_item_i;
      cnt_q <= '0;
      hit_q <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      ridx_q <= iss_q[IW-1:0];
      if (rv_q) begin
        cnt_q <= cnt_q + CW'(rd_on);
        if (rd_addr_q == cur_q.addr) begin
          hit_q     <= 1'b1;
          hit_idx_q <= ridx_q;
          hit_on_q  <= rd_on;
        end
        if (ridx_q == '0 || rd_seen_q < old_t_q) begin
          old_idx_q <= ridx_q;
          old_t_q   <= rd_seen_q;
          old_on_q  <= rd_on;
        end
      end
    end
    if (load_out) begin
      o_online_q <= online_sat;
      o_opeak_q  <= opeak_d;
      o_total_q  <= total_d;
      o_act_q    <= act_d;
      o_apeak_q  <= apeak_d;
      o_up_q     <= up_val;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign live_count_o    = o_online_q;
  assign live_peak_o     = o_opeak_q;
  assign request_count_o = o_total_q;
  assign open_conns_o    = o_act_q;
  assign peak_active_o   = o_apeak_q;
  assign uptime_o        = o_up_q;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= used_q))
    else $error("scan index passed fill count");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FIN) |=> (used_q == $past(used_q)))
    else $error("fill count moved outside finish");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == ST_FIN && !more && !rv_q))
    else $error("result loaded with scan pending");
`endif

endmodule
